### hdl/sdsh_pkg.sv
// Shared types, codes and constants of the SD card SPI-mode host sequencer.
package sdsh_pkg;

  localparam int ModeW = 3;

  typedef enum logic [2:0] {
    MODE_INIT  = 3'd0,
    MODE_CMD   = 3'd1,
    MODE_READ  = 3'd2,
    MODE_WRITE = 3'd3,
    MODE_XCHG  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    JOB_INIT  = 2'd0,
    JOB_CMD   = 2'd1,
    JOB_READ  = 2'd2,
    JOB_WRITE = 2'd3
  } job_e;

  typedef enum logic [4:0] {
    PH_IDLE, PH_CLK, PH_FRAME, PH_R1, PH_I_REL0, PH_I_OCR, PH_I_REL1, PH_I_REL2,
    PH_I_FIN, PH_R_TOKEN, PH_R_DATA, PH_R_TAIL1, PH_R_TAIL2, PH_W_REL, PH_W_TOKEN,
    PH_W_DATA, PH_W_CRC1, PH_W_CRC2, PH_W_RESP, PH_W_BUSY
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_R1_ERR    = 3'd1,
    ST_TOKEN_TO  = 3'd2,
    ST_WR_REJ    = 3'd3,
    ST_BUSY_TO   = 3'd4,
    ST_INIT_FAIL = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    REG_RESP_TRIES = 3'd0,
    REG_WAIT_LIMIT = 3'd1,
    REG_CLK_BYTES  = 3'd2,
    REG_ATTEMPTS   = 3'd3,
    REG_CMD1_LIMIT = 3'd4
  } reg_e;

  localparam logic [7:0] CmdGoIdle  = 8'h40;
  localparam logic [7:0] CmdIfCond  = 8'h48;
  localparam logic [7:0] CmdOpCond  = 8'h41;
  localparam logic [7:0] CmdRead    = 8'h51;
  localparam logic [7:0] CmdWrite   = 8'h58;
  localparam logic [7:0] ByteIdle   = 8'hFF;
  localparam logic [7:0] DataToken  = 8'hFE;
  localparam logic [31:0] ArgIfCond = 32'h0000_01AA;
  localparam logic [31:0] ArgOpCond = 32'h4000_0000;

  // Request decoded by the front end.
  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  cmd_byte;
    logic [31:0] argument;
    logic [7:0]  rx_byte;
    logic [7:0]  wr_data;
  } req_t;

  // Register file seen by the back end.
  typedef struct packed {
    logic [7:0]  response_tries;
    logic [15:0] wait_limit;
    logic [7:0]  init_clock_bytes;
    logic [3:0]  init_attempts;
    logic [15:0] cmd1_poll_limit;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       cs_low;
    logic [7:0] rd_byte;
    logic       rd_valid;
    logic [7:0] r1_value;
    logic       done_res;
    logic [2:0] status;
  } res_t;

  function automatic logic [7:0] crc_for(input logic [7:0] c, input logic [31:0] a);
    logic [7:0] n;
    n = 8'h01;
    if (c == 8'h40) n = 8'h95;
    if (c == 8'h48) n = 8'h87;
    if (c == 8'h77) n = 8'h65;
    if (c == 8'h41) n = 8'hF9;
    if (c == 8'hE9 && a == 32'h4000_0000) n = 8'h77;
    if (c == 8'hE9 && a == 32'h0) n = 8'hE5;
    return n;
  endfunction

endpackage

### hdl/sdsh_front.sv
// Front end: accepts request items, drops ignored ones, feeds a two-entry queue.
module sdsh_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sdsh_pkg::req_t in_req_i,
  input  logic          busy_i,
  output logic          q_valid_o,
  input  logic          q_ready_i,
  output sdsh_pkg::req_t q_req_o
);
  import sdsh_pkg::*;

  req_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop, keep;

  // Exchange items are only meaningful while a job runs in or ahead of the back end.
  assign keep = (in_req_i.mode < MODE_XCHG) ||
                (in_req_i.mode == MODE_XCHG && (busy_i || cnt_q != 2'd0));
  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o && keep;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop = q_valid_o && q_ready_i;
  assign q_req_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

### hdl/sdsh_back.sv
// Back end: job sequencer that turns queued items into result items.
module sdsh_back #(
  parameter int BLOCK_BYTES = 512
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sdsh_pkg::cfg_t cfg_i,
  input  logic           q_valid_i,
  output logic           q_ready_o,
  input  sdsh_pkg::req_t q_req_i,
  output logic           busy_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sdsh_pkg::res_t out_res_o
);
  import sdsh_pkg::*;

  localparam logic [15:0] Blk = 16'(BLOCK_BYTES);

  phase_e      ph_q, ph_d;
  job_e        job_q, job_d;
  logic [15:0] bc_q, bc_d, pc_q, pc_d;
  logic [7:0]  hc_q, hc_d, lr_q, lr_d;
  logic [31:0] ha_q, ha_d;
  logic [3:0]  at_q, at_d;
  logic        ocr_q, ocr_d;
  logic [2:0]  err_q, err_d;
  logic        ov_q;
  res_t        res_q, r;
  logic        take, drop;
  logic [7:0]  rx, fb;
  logic [7:0]  rt, icb;
  logic [15:0] wl, c1l;
  logic [3:0]  ia;

  assign rt  = (cfg_i.response_tries == 8'd0) ? 8'd1 : cfg_i.response_tries;
  assign wl  = (cfg_i.wait_limit == 16'd0) ? 16'd1 : cfg_i.wait_limit;
  assign icb = (cfg_i.init_clock_bytes == 8'd0) ? 8'd1 : cfg_i.init_clock_bytes;
  assign ia  = (cfg_i.init_attempts == 4'd0) ? 4'd1 : cfg_i.init_attempts;
  assign c1l = (cfg_i.cmd1_poll_limit == 16'd0) ? 16'd1 : cfg_i.cmd1_poll_limit;

  assign q_ready_o   = !ov_q || out_ready_i;
  assign take        = q_valid_i && q_ready_o;
  // An exchange item that reaches an idle sequencer is consumed without a result.
  assign drop        = (q_req_i.mode == MODE_XCHG) && (ph_q == PH_IDLE);
  assign busy_o      = (ph_q != PH_IDLE);
  assign out_valid_o = ov_q;
  assign out_res_o   = res_q;
  assign rx          = q_req_i.rx_byte;

  always_comb begin
    case (pc_q[2:0])
      3'd1:    fb = ha_q[31:24];
      3'd2:    fb = ha_q[23:16];
      3'd3:    fb = ha_q[15:8];
      3'd4:    fb = ha_q[7:0];
      default: fb = crc_for(hc_q, ha_q);
    endcase
  end

  always_comb begin
    logic fail, fin, flg;
    logic [2:0] code;
    logic sc;
    logic [7:0] sc_c;
    logic [31:0] sc_a;
    ph_d = ph_q; job_d = job_q; bc_d = bc_q; pc_d = pc_q; hc_d = hc_q; ha_d = ha_q;
    at_d = at_q; ocr_d = ocr_q; err_d = err_q; lr_d = lr_q;
    r = '0;
    fail = 1'b0; fin = 1'b0; flg = 1'b0; code = ST_OK;
    sc = 1'b0; sc_c = 8'h00; sc_a = 32'h0;
    if (q_req_i.mode != MODE_XCHG) begin
      err_d = ST_OK;
      job_d = job_e'(q_req_i.mode[1:0]);
      case (q_req_i.mode)
        MODE_INIT: begin
          at_d = 4'd0; ph_d = PH_CLK; bc_d = 16'd1; r.tx_byte = ByteIdle; r.tx_valid = 1'b1;
        end
        MODE_CMD:  begin sc = 1'b1; sc_c = q_req_i.cmd_byte; sc_a = q_req_i.argument; end
        MODE_READ: begin sc = 1'b1; sc_c = CmdRead; sc_a = q_req_i.argument; end
        default:   begin sc = 1'b1; sc_c = CmdWrite; sc_a = q_req_i.argument; end
      endcase
    end else begin
      r.tx_byte = ByteIdle; r.tx_valid = 1'b1;
      case (ph_q)
        PH_CLK:
          if (bc_q < {8'd0, icb}) bc_d = bc_q + 16'd1;
          else begin sc = 1'b1; sc_c = CmdGoIdle; end
        PH_FRAME:
          if (pc_q < 16'd6) begin r.tx_byte = fb; pc_d = pc_q + 16'd1; end
          else begin ph_d = PH_R1; pc_d = 16'd1; end
        PH_R1: begin
          lr_d = rx;
          if (!rx[7] || pc_q >= {8'd0, rt}) begin
            case (job_q)
              JOB_INIT:
                if (hc_q == CmdGoIdle) begin
                  if (rx == 8'h01) ph_d = PH_I_REL0; else fail = 1'b1;
                end else if (hc_q == CmdIfCond) begin
                  if (rx == 8'h01) begin ph_d = PH_I_OCR; bc_d = 16'd0; ocr_d = 1'b0; end
                  else fail = 1'b1;
                end else begin
                  if (rx == 8'h00) ph_d = PH_I_FIN;
                  else if (bc_q >= c1l) begin flg = 1'b1; code = ST_INIT_FAIL; fin = 1'b1; end
                  else begin bc_d = bc_q + 16'd1; ph_d = PH_I_REL2; end
                end
              JOB_CMD: begin flg = rx[7]; code = ST_R1_ERR; fin = 1'b1; end
              JOB_READ: begin
                flg = (rx != 8'h00); code = ST_R1_ERR; ph_d = PH_R_TOKEN; pc_d = 16'd1;
              end
              default: begin flg = (rx != 8'h00); code = ST_R1_ERR; ph_d = PH_W_REL; end
            endcase
          end else pc_d = pc_q + 16'd1;
        end
        PH_I_REL0: begin sc = 1'b1; sc_c = CmdIfCond; sc_a = ArgIfCond; end
        PH_I_OCR: begin
          if (bc_q == 16'd2) ocr_d = (rx == 8'h01);
          if (bc_q == 16'd3) ocr_d = ocr_q && (rx == 8'hAA);
          bc_d = bc_q + 16'd1;
          if (bc_q + 16'd1 >= 16'd4) begin
            if (ocr_d) ph_d = PH_I_REL1; else fail = 1'b1;
          end
        end
        PH_I_REL1: begin ph_d = PH_I_REL2; bc_d = 16'd1; end
        PH_I_REL2: begin sc = 1'b1; sc_c = CmdOpCond; sc_a = ArgOpCond; end
        PH_I_FIN:  fin = 1'b1;
        PH_R_TOKEN:
          if (rx == DataToken) begin ph_d = PH_R_DATA; bc_d = 16'd0; end
          else if (pc_q >= wl) begin
            flg = 1'b1; code = ST_TOKEN_TO; ph_d = PH_R_DATA; bc_d = 16'd0;
          end else pc_d = pc_q + 16'd1;
        PH_R_DATA: begin
          r.rd_byte = rx; r.rd_valid = 1'b1; bc_d = bc_q + 16'd1;
          if (bc_d >= Blk) ph_d = PH_R_TAIL1;
        end
        PH_R_TAIL1: ph_d = PH_R_TAIL2;
        PH_R_TAIL2: fin = 1'b1;
        PH_W_REL:   begin ph_d = PH_W_TOKEN; r.tx_byte = DataToken; end
        PH_W_TOKEN: begin ph_d = PH_W_DATA; bc_d = 16'd1; r.tx_byte = q_req_i.wr_data; end
        PH_W_DATA:
          if (bc_q < Blk) begin bc_d = bc_q + 16'd1; r.tx_byte = q_req_i.wr_data; end
          else ph_d = PH_W_CRC1;
        PH_W_CRC1: ph_d = PH_W_CRC2;
        PH_W_CRC2: ph_d = PH_W_RESP;
        PH_W_RESP: begin
          flg = (rx[0] & rx[2]) == 1'b0; code = ST_WR_REJ; ph_d = PH_W_BUSY; pc_d = 16'd1;
        end
        PH_W_BUSY:
          if (rx == ByteIdle) fin = 1'b1;
          else if (pc_q >= wl) begin flg = 1'b1; code = ST_BUSY_TO; fin = 1'b1; end
          else pc_d = pc_q + 16'd1;
        default: fin = 1'b1;
      endcase
    end
    if (fail) begin
      at_d = at_q + 4'd1;
      if (at_d >= ia) begin flg = 1'b1; code = ST_INIT_FAIL; fin = 1'b1; end
      else begin ph_d = PH_CLK; bc_d = 16'd1; end
    end
    if (sc) begin
      hc_d = sc_c; ha_d = sc_a; ph_d = PH_FRAME; pc_d = 16'd1;
      r.tx_byte = sc_c; r.tx_valid = 1'b1;
    end
    if (flg && err_d == ST_OK) err_d = code;
    if (fin) begin ph_d = PH_IDLE; r.done_res = 1'b1; r.tx_byte = 8'h00; r.tx_valid = 1'b0; end
    r.cs_low = (ph_d != PH_CLK);
    r.r1_value = lr_d;
    r.status = err_d;
  end

  always_ff @(posedge clk_i) begin
    if (take && !drop) res_q <= r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_IDLE; job_q <= JOB_INIT; bc_q <= '0; pc_q <= '0; hc_q <= '0; ha_q <= '0;
      at_q <= '0; ocr_q <= 1'b0; err_q <= ST_OK; lr_q <= 8'hFF; ov_q <= 1'b0;
    end else begin
      if (take && !drop) begin
        ph_q <= ph_d; job_q <= job_d; bc_q <= bc_d; pc_q <= pc_d; hc_q <= hc_d; ha_q <= ha_d;
        at_q <= at_d; ocr_q <= ocr_d; err_q <= err_d; lr_q <= lr_d;
        ov_q <= 1'b1;
      end else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !drop && r.done_res |=> ph_q == PH_IDLE) else $error("done without idle");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ready_i |=> $stable(res_q)) else $error("result changed while stalled");
  a_rd_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && res_q.done_res |-> !res_q.tx_valid && !res_q.rd_valid) else $error("done with data");
endmodule

### hdl/sd_spi_mode_host_sequencer_unit.sv
// Top level of the SD card SPI-mode host sequencer.
// The slave channel s_axis_* carries request and exchange items. mode 0..3
// starts init, one command, a block read or a block write, and the result
// item carries the first byte to send. Each mode 4 item reports the byte
// received on the SPI exchange just finished (and, during the write data
// phase, the next payload byte); its result gives the next byte to send.
// A result with done_res set ends the job. Exchange items while no job is
// running, and modes 5 to 7, are dropped and give no result.
// A front end filters items into a two-entry queue; the back end runs the
// phase sequencer into a result register, one queued item per cycle while
// the master side takes results. An accepted item is written into the
// queue, taken from there by the sequencer, and its result is held in the
// result register until the master side takes it. The SPI byte time sets
// the pace. When the master side stalls, the result register holds and
// the queue fills; the slave side then drops tready after two more items.
// Reset clears the sequencer to idle and loads the register defaults.
// Configuration is written via cfg_we_i/cfg_idx_i/cfg_data_i; the user
// must write it only while idle, which the block itself does not enforce.
module sd_spi_mode_host_sequencer_unit #(
  parameter int BLOCK_BYTES = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // mode[2:0], cmd_byte[10:3], argument[42:11], rx_byte[50:43], wr_data[58:51]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tx_byte[7:0], tx_valid[8], cs_low[9], rd_byte[17:10], rd_valid[18],
  // r1_value[26:19], done_res[27], status[30:28]
  output logic [31:0] m_axis_tdata
);
  import sdsh_pkg::*;

  cfg_t cfg_q;
  req_t in_req, q_req;
  res_t res;
  logic q_valid, q_ready, busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{response_tries: 8'd10, wait_limit: 16'hFFFF, init_clock_bytes: 8'd200,
                 init_attempts: 4'd6, cmd1_poll_limit: 16'hFFFF};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RESP_TRIES: cfg_q.response_tries   <= cfg_data_i[7:0];
        REG_WAIT_LIMIT: cfg_q.wait_limit       <= cfg_data_i;
        REG_CLK_BYTES:  cfg_q.init_clock_bytes <= cfg_data_i[7:0];
        REG_ATTEMPTS:   cfg_q.init_attempts    <= cfg_data_i[3:0];
        REG_CMD1_LIMIT: cfg_q.cmd1_poll_limit  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_req.mode     = s_axis_tdata[2:0];
  assign in_req.cmd_byte = s_axis_tdata[10:3];
  assign in_req.argument = s_axis_tdata[42:11];
  assign in_req.rx_byte  = s_axis_tdata[50:43];
  assign in_req.wr_data  = s_axis_tdata[58:51];

  sdsh_front u_front (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_req_i(in_req), .busy_i(busy), .q_valid_o(q_valid), .q_ready_i(q_ready),
    .q_req_o(q_req)
  );

  sdsh_back #(.BLOCK_BYTES(BLOCK_BYTES)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .q_valid_i(q_valid), .q_ready_o(q_ready),
    .q_req_i(q_req), .busy_o(busy), .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready), .out_res_o(res)
  );

  assign m_axis_tdata = {1'b0, res.status, res.done_res, res.r1_value, res.rd_valid,
                         res.rd_byte, res.cs_low, res.tx_valid, res.tx_byte};
endmodule

### sim/testbench.sv
// Self-checking testbench for the SD card SPI-mode host sequencer top level.
//
// A scoreboard class carries an item-by-item predictor of the sequencer. It
// holds its own copy of the job state and the register values. Every item
// accepted on the slave side goes through the predictor. Each item that
// gives a result queues one expected result item, and each item taken on
// the master side is compared field by field with the oldest one.
//
// The stimulus plays the card. The reply byte of each exchange item is
// chosen from the predicted phase: mostly the answer a working card gives,
// sometimes a wrong byte, a timeout or plain noise. This lets init, the
// commands, the reads and the writes all run to their later phases. Jobs are
// also cut short by new requests, and items are mixed in that the block
// should drop.
module testbench;
  import sdsh_pkg::*;

  localparam int CycleLimit = 1_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  // The scoreboard predicts the sequencer and holds the result items that
  // are still due. A result is packed here exactly as on m_axis_tdata.
  class spi_host_scoreboard;
    int unsigned resp_tries, wait_lim, clk_bytes, attempts_cfg, cmd1_lim;
    phase_e      ph;
    job_e        job;
    logic [15:0] bcnt, pcnt;
    logic [7:0]  hcmd, last_r1;
    logic [31:0] harg;
    logic [3:0]  att;
    bit          ocr;
    logic [2:0]  err;
    logic [7:0]  tx, rd;
    bit          txv, rdv, done;
    logic [30:0] due_results[$];
    int          mismatches, results_seen, jobs_done;

    function new();
      resp_tries = 10; wait_lim = 65535; clk_bytes = 200;
      attempts_cfg = 6; cmd1_lim = 65535;
      ph = PH_IDLE; job = JOB_INIT; bcnt = '0; pcnt = '0;
      hcmd = '0; harg = '0; att = '0; ocr = 0; err = ST_OK; last_r1 = 8'hFF;
      mismatches = 0; results_seen = 0; jobs_done = 0;
    endfunction

    function void set_reg(reg_e idx, logic [15:0] v);
      case (idx)
        REG_RESP_TRIES: resp_tries = v[7:0];
        REG_WAIT_LIMIT: wait_lim = v;
        REG_CLK_BYTES:  clk_bytes = v[7:0];
        REG_ATTEMPTS:   attempts_cfg = v[3:0];
        REG_CMD1_LIMIT: cmd1_lim = v;
        default: ;
      endcase
    endfunction

    // A count register that holds zero behaves as if it held one.
    function int unsigned floor1(int unsigned v);
      return (v == 0) ? 1 : v;
    endfunction

    // Only the first error of a job is kept.
    function void flag(status_e code);
      if (err == ST_OK) err = code;
    endfunction

    function void put(logic [7:0] b);
      tx = b; txv = 1;
    endfunction

    function void finish();
      ph = PH_IDLE; done = 1;
    endfunction

    // CRC byte of a command frame: known commands get their real CRC.
    function logic [7:0] frame_crc(logic [7:0] c, logic [31:0] a);
      if (c == 8'hE9) return (a == 32'h4000_0000) ? 8'h77 : (a == 32'h0) ? 8'hE5 : 8'h01;
      case (c)
        8'h40: return 8'h95;
        8'h48: return 8'h87;
        8'h77: return 8'h65;
        8'h41: return 8'hF9;
        default: return 8'h01;
      endcase
    endfunction

    function logic [7:0] frame_byte(logic [15:0] idx);
      if (idx == 0) return hcmd;
      if (idx <= 4) return 8'(harg >> (8 * (4 - idx)));
      return frame_crc(hcmd, harg);
    endfunction

    function void start_cmd(logic [7:0] c, logic [31:0] a);
      hcmd = c; harg = a; ph = PH_FRAME; pcnt = 1; put(c);
    endfunction

    function void start_attempt();
      ph = PH_CLK; bcnt = 1; put(ByteIdle);
    endfunction

    function void fail_attempt();
      att = att + 4'd1;
      if (att >= floor1(attempts_cfg)) begin
        flag(ST_INIT_FAIL); finish();
      end else start_attempt();
    endfunction

    // What follows the end of R1 polling depends on the job and, during init,
    // on which command was sent.
    function void r1_done(logic [7:0] rx);
      case (job)
        JOB_INIT: begin
          if (hcmd == CmdGoIdle) begin
            if (rx == 8'h01) begin
              ph = PH_I_REL0; put(ByteIdle);
            end else fail_attempt();
          end else if (hcmd == CmdIfCond) begin
            if (rx == 8'h01) begin
              ph = PH_I_OCR; bcnt = 0; ocr = 0; put(ByteIdle);
            end else fail_attempt();
          end else if (rx == 8'h00) begin
            ph = PH_I_FIN; put(ByteIdle);
          end else if (bcnt >= floor1(cmd1_lim)) begin
            flag(ST_INIT_FAIL); finish();
          end else begin
            bcnt++; ph = PH_I_REL2; put(ByteIdle);
          end
        end
        JOB_CMD: begin
          if (rx[7]) flag(ST_R1_ERR);
          finish();
        end
        JOB_READ: begin
          if (rx != 0) flag(ST_R1_ERR);
          ph = PH_R_TOKEN; pcnt = 1; put(ByteIdle);
        end
        default: begin
          if (rx != 0) flag(ST_R1_ERR);
          ph = PH_W_REL; put(ByteIdle);
        end
      endcase
    endfunction

    function void exchange(logic [7:0] rx, logic [7:0] wr);
      case (ph)
        PH_CLK:
          if (bcnt < floor1(clk_bytes)) begin
            bcnt++; put(ByteIdle);
          end else start_cmd(CmdGoIdle, 32'h0);
        PH_FRAME:
          if (pcnt < 6) begin
            put(frame_byte(pcnt)); pcnt++;
          end else begin
            ph = PH_R1; pcnt = 1; put(ByteIdle);
          end
        PH_R1: begin
          last_r1 = rx;
          if (!rx[7] || pcnt >= floor1(resp_tries)) r1_done(rx);
          else begin
            pcnt++; put(ByteIdle);
          end
        end
        PH_I_REL0: start_cmd(CmdIfCond, ArgIfCond);
        PH_I_OCR: begin
          // The last two OCR bytes must echo the voltage range and pattern.
          if (bcnt == 2) ocr = (rx == 8'h01);
          if (bcnt == 3) ocr = ocr && (rx == 8'hAA);
          bcnt++;
          if (bcnt < 4) put(ByteIdle);
          else if (ocr) begin
            ph = PH_I_REL1; put(ByteIdle);
          end else fail_attempt();
        end
        PH_I_REL1: begin
          ph = PH_I_REL2; bcnt = 1; put(ByteIdle);
        end
        PH_I_REL2: start_cmd(CmdOpCond, ArgOpCond);
        PH_I_FIN: finish();
        PH_R_TOKEN:
          if (rx == DataToken) begin
            ph = PH_R_DATA; bcnt = 0; put(ByteIdle);
          end else if (pcnt >= floor1(wait_lim)) begin
            flag(ST_TOKEN_TO); ph = PH_R_DATA; bcnt = 0; put(ByteIdle);
          end else begin
            pcnt++; put(ByteIdle);
          end
        PH_R_DATA: begin
          rd = rx; rdv = 1; bcnt++;
          if (bcnt >= 512) ph = PH_R_TAIL1;
          put(ByteIdle);
        end
        PH_R_TAIL1: begin
          ph = PH_R_TAIL2; put(ByteIdle);
        end
        PH_R_TAIL2: finish();
        PH_W_REL: begin
          ph = PH_W_TOKEN; put(DataToken);
        end
        PH_W_TOKEN: begin
          ph = PH_W_DATA; bcnt = 1; put(wr);
        end
        PH_W_DATA:
          if (bcnt < 512) begin
            bcnt++; put(wr);
          end else begin
            ph = PH_W_CRC1; put(ByteIdle);
          end
        PH_W_CRC1: begin
          ph = PH_W_CRC2; put(ByteIdle);
        end
        PH_W_CRC2: begin
          ph = PH_W_RESP; put(ByteIdle);
        end
        PH_W_RESP: begin
          if ((rx & 8'h05) != 8'h05) flag(ST_WR_REJ);
          ph = PH_W_BUSY; pcnt = 1; put(ByteIdle);
        end
        PH_W_BUSY:
          if (rx == ByteIdle) finish();
          else if (pcnt >= floor1(wait_lim)) begin
            flag(ST_BUSY_TO); finish();
          end else begin
            pcnt++; put(ByteIdle);
          end
        default: finish();
      endcase
    endfunction

    // Called for every accepted input item.
    function void note_input(logic [2:0] mode, logic [7:0] cmd, logic [31:0] arg,
                             logic [7:0] rx, logic [7:0] wr);
      if (mode > MODE_XCHG || (mode == MODE_XCHG && ph == PH_IDLE)) return;
      tx = '0; txv = 0; rd = '0; rdv = 0; done = 0;
      if (mode == MODE_XCHG) exchange(rx, wr);
      else begin
        err = ST_OK;
        job = job_e'(mode[1:0]);
        case (mode)
          MODE_INIT: begin
            att = '0; start_attempt();
          end
          MODE_CMD:  start_cmd(cmd, arg);
          MODE_READ: start_cmd(CmdRead, arg);
          default:   start_cmd(CmdWrite, arg);
        endcase
      end
      if (done) jobs_done++;
      due_results.push_back({err, done, last_r1, rdv, rd, ph != PH_CLK, txv, tx});
    endfunction

    // Called for every accepted result item.
    function void check_result(logic [31:0] d);
      logic [30:0] e;
      results_seen++;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result %h arrived with none expected", d);
        return;
      end
      e = due_results.pop_front();
      if (d[7:0] !== e[7:0] || d[8] !== e[8] || d[9] !== e[9] || d[17:10] !== e[17:10] ||
          d[18] !== e[18] || d[26:19] !== e[26:19] || d[27] !== e[27] ||
          d[30:28] !== e[30:28]) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"ERROR: result %0d: tx %h/%h txv %b/%b cs %b/%b rd %h/%h rdv %b/%b ",
                    "r1 %h/%h done %b/%b status %0d/%0d (expected/actual)"},
                   results_seen, e[7:0], d[7:0], e[8], d[8], e[9], d[9], e[17:10],
                   d[17:10], e[18], d[18], e[26:19], d[26:19], e[27], d[27], e[30:28],
                   d[30:28]);
      end
    endfunction
  endclass

  spi_host_scoreboard sb = new();
  int send_idle_pct, recv_idle_pct;
  int cycles, items_sent;

  sd_spi_mode_host_sequencer_unit DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #5 clk_i = ~clk_i;

  // The receiver stalls at random, results are checked as they are taken,
  // and the cycle counter guards against a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench failed");
      $finish;
    end
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // The card side: pick a reply that fits the phase the sequencer is in.
  // Mostly the right answer, now and then a wrong byte or a timeout.
  function automatic logic [7:0] card_reply();
    int r;
    r = $urandom_range(99);
    case (sb.ph)
      PH_R1: begin
        if (r < 25) return ByteIdle;
        if (sb.job == JOB_INIT) begin
          if (sb.hcmd == CmdOpCond) return (r < 60) ? 8'h00 : 8'h01;
          return (r < 90) ? 8'h01 : 8'($urandom);
        end
        return (r < 70) ? 8'h00 : 8'($urandom);
      end
      PH_I_OCR: begin
        if (sb.bcnt == 2 && r < 90) return 8'h01;
        if (sb.bcnt == 3 && r < 90) return 8'hAA;
        return 8'($urandom);
      end
      PH_R_TOKEN: return (r < 30) ? DataToken : (r < 80) ? ByteIdle : 8'($urandom);
      PH_W_RESP:  return (r < 80) ? (8'($urandom) | 8'h05) : 8'($urandom);
      PH_W_BUSY:  return (r < 30) ? ByteIdle : (r < 80) ? 8'h00 : 8'($urandom);
      default:    return 8'($urandom);
    endcase
  endfunction

  task automatic send_item(logic [2:0] mode, logic [7:0] cmd, logic [31:0] arg,
                           logic [7:0] rx, logic [7:0] wr);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {5'd0, wr, rx, arg, cmd, mode};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(mode, cmd, arg, rx, wr);
    items_sent++;
  endtask

  task automatic exchange_item();
    send_item(MODE_XCHG, 8'($urandom), $urandom, card_reply(), 8'($urandom));
  endtask

  task automatic start_job(mode_e mode);
    logic [7:0]  cmd;
    logic [31:0] arg;
    cmd = 8'($urandom);
    arg = $urandom;
    // Favor the commands that carry a real CRC byte.
    case ($urandom_range(7))
      0: cmd = 8'h40;
      1: cmd = 8'h48;
      2: cmd = 8'h77;
      3: cmd = 8'h41;
      4: begin
        cmd = 8'hE9;
        arg = $urandom_range(1) ? ArgOpCond : 32'h0;
      end
      default: ;
    endcase
    send_item(mode, cmd, arg, 8'($urandom), 8'($urandom));
  endtask

  task automatic run_to_idle();
    while (sb.ph != PH_IDLE) exchange_item();
  endtask

  // Random jobs until the item budget is spent. Block jobs are mostly cut
  // short by the next request; a block job still open at the end is cut by
  // one last command, which runs to its end.
  task automatic random_jobs(int budget);
    int stop_at, n, r;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 8) begin
        send_item(sb.ph == PH_IDLE ? 3'(MODE_XCHG) : 3'($urandom_range(5, 7)),
                  8'($urandom), $urandom, 8'($urandom), 8'($urandom));
      end else begin
        if (r < 22) start_job(MODE_INIT);
        else if (r < 60) start_job(MODE_CMD);
        else if (r < 80) start_job(MODE_READ);
        else start_job(MODE_WRITE);
        if (sb.job == JOB_READ || sb.job == JOB_WRITE) n = $urandom_range(1, 60);
        else if ($urandom_range(99) < 20) n = $urandom_range(1, 15);
        else n = 1 << 30;
        while (sb.ph != PH_IDLE && n > 0) begin
          exchange_item();
          n--;
        end
      end
    end
    if (sb.ph != PH_IDLE && (sb.job == JOB_READ || sb.job == JOB_WRITE))
      start_job(MODE_CMD);
    run_to_idle();
  endtask

  task automatic write_regs(logic [15:0] tries, logic [15:0] wlim, logic [15:0] clkb,
                            logic [15:0] atts, logic [15:0] c1lim);
    logic [15:0] vals[5];
    vals = '{tries, wlim, clkb, atts, c1lim};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= 3'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      sb.set_reg(reg_e'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Stop sending, wait until every expected result is in, then let the pipe settle.
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cycles = 0;
    items_sent = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: dropped items, then short commands with the CRC table edges.
    write_regs(16'd1, 16'd65535, 16'd10, 16'd6, 16'd65535);
    send_item(MODE_XCHG, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    send_item(3'd5, 8'h00, 32'h0, 8'h00, 8'h00);
    send_item(3'd6, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    send_item(3'd7, 8'hAA, 32'h5555_5555, 8'h55, 8'hAA);
    send_item(MODE_CMD, 8'hE9, ArgOpCond, 8'h00, 8'h00);
    run_to_idle();
    send_item(MODE_CMD, 8'hE9, 32'h0, 8'h00, 8'h00);
    run_to_idle();
    send_item(MODE_CMD, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    run_to_idle();
    wait_quiet();

    // Low extremes of every register but the clock byte count; sender idles less than receiver.
    write_regs(16'd1, 16'd1, 16'd10, 16'd1, 16'd1);
    send_idle_pct = 31;
    recv_idle_pct = 75;
    random_jobs(190);
    wait_quiet();

    // Zero counts that act as one, and the top of the retry ranges.
    write_regs(16'd255, 16'd0, 16'd0, 16'd15, 16'd0);
    send_idle_pct = 75;
    recv_idle_pct = 31;
    random_jobs(190);
    wait_quiet();

    // Wide wait and poll limits, no idling.
    write_regs(16'd4, 16'd65535, 16'd40, 16'd2, 16'd65535);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_jobs(190);
    wait_quiet();

    $display("run covered %0d input items, %0d results and %0d finished jobs",
             items_sent, sb.results_seen, sb.jobs_done);
    $display("across four register settings; %0d mismatches", sb.mismatches);
    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

### sd_spi_mode_host_sequencer_unit.f
hdl/sdsh_pkg.sv
hdl/sdsh_front.sv
hdl/sdsh_back.sv
hdl/sd_spi_mode_host_sequencer_unit.sv
sim/testbench.sv
